// ----- rtl/cbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the passive cell balancing controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int SEGMENTS_DEF = 10;
    localparam int CELLS_DEF    = 14;

    localparam int VOLT_W     = 16;
    localparam int TICK_W     = 32;
    localparam int MASK_W     = 14;
    localparam int LOC_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE   = 2'd2;

    localparam logic [VOLT_W-1:0] THRESHOLD_RST = 16'd100;
    localparam logic [TICK_W-1:0] SETTLE_RST    = 32'd30000;
    localparam logic [TICK_W-1:0] BALANCE_RST   = 32'd300000;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_SETTLE   = 2'd1,
        MODE_BALANCE  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_TAIL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        TICK_PLAIN,
        TICK_WALK,
        TICK_MASKS
    } tick_kind_t;

    typedef struct packed {
        logic              cmd;
        logic [LOC_W-1:0]  cell_segment;
        logic [LOC_W-1:0]  cell_index;
        logic [VOLT_W-1:0] cell_voltage;
        logic              cell_valid;
        logic              enable;
        logic [LOC_W-1:0]  min_segment;
        logic [LOC_W-1:0]  min_index;
        logic [VOLT_W-1:0] min_voltage;
        logic [VOLT_W-1:0] max_voltage;
    } item_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LOC_W-1:0]  leader_segment;
        logic [LOC_W-1:0]  leader_index;
        logic [VOLT_W-1:0] imbalance;
        logic [LOC_W-1:0]  mask_segment;
        logic [MASK_W-1:0] discharge_mask;
        logic              mask_present;
        logic              last;
    } result_t;

    typedef struct packed {
        logic report_wr;
        logic tick_load;
        logic clear_step;
        logic walk_step;
        logic emit_step;
    } dp_cmd_t;

    typedef struct packed {
        tick_kind_t tick_kind;
        logic       addr_last;
        logic       emit_last;
    } dp_status_t;

endpackage

// ----- rtl/cbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_ctrl
// Sequencer: store clear after reset, cell walk and result emission.
// ----------------------------------------------------------------------------
module cbc_ctrl
    import cbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       item_cmd,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (item_cmd == CMD_REPORT)
                    begin
                        cmd.report_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.tick_load = 1'b1;
                        state_next = (status.tick_kind == TICK_WALK) ? ST_WALK : ST_EMIT;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cbc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_datapath
// Cell store, mode timers, leader, mask computation and result register.
// ----------------------------------------------------------------------------
module cbc_datapath
    import cbc_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF,
    parameter int CELLS    = CELLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 item,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output result_t               result,
    output logic                  strobe
);

    localparam int DEPTH  = SEGMENTS * CELLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    // configuration
    logic [VOLT_W-1:0] thr_reg;
    logic [TICK_W-1:0] settle_reg;
    logic [TICK_W-1:0] balance_reg;

    // control state
    mode_t             mode_reg,        mode_next;
    logic [TICK_W-1:0] elapsed_reg,     elapsed_next;
    logic [LOC_W-1:0]  leader_seg_reg,  leader_seg_next;
    logic [LOC_W-1:0]  leader_cell_reg, leader_cell_next;
    logic [VOLT_W-1:0] leader_volt_reg, leader_volt_next;
    logic [MASK_W-1:0] mask_reg [SEGMENTS];
    logic [MASK_W-1:0] mask_next [SEGMENTS];
    logic              emit_masks_reg;
    logic [ADDR_W-1:0] addr_cnt_reg,    addr_cnt_next;
    logic [SEG_W-1:0]  seg_cnt_reg,     seg_cnt_next;
    logic [CELL_W-1:0] cell_cnt_reg,    cell_cnt_next;
    logic [SEG_W-1:0]  emit_cnt_reg,    emit_cnt_next;
    logic              eval_reg;
    logic              strobe_reg;

    // payload
    logic [VOLT_W-1:0] imb_reg;
    logic [VOLT_W:0]   rd_reg;
    logic [SEG_W-1:0]  seg_d_reg;
    logic [CELL_W-1:0] cell_d_reg;
    result_t           result_reg,      result_next;

    logic [VOLT_W:0]   cell_mem [DEPTH];

    // tick evaluation
    tick_kind_t        kind;
    mode_t             mode_t_val;
    logic [TICK_W-1:0] elapsed_inc;
    logic [TICK_W-1:0] elapsed_t_val;
    logic [LOC_W-1:0]  lseg_t, lcell_t;
    logic [VOLT_W-1:0] lvolt_t;

    logic              rep_in_range;
    logic [ADDR_W-1:0] rep_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VOLT_W:0]   mem_wdata;
    logic              leader_match;
    logic              hit;
    logic              cnt_step;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        kind          = TICK_PLAIN;
        mode_t_val    = mode_reg;
        elapsed_t_val = elapsed_reg;
        lseg_t        = leader_seg_reg;
        lcell_t       = leader_cell_reg;
        lvolt_t       = leader_volt_reg;
        case (mode_reg)
            MODE_SETTLE:
            begin
                if (!item.enable)
                begin
                    mode_t_val = MODE_DISABLED;
                end
                else if (elapsed_inc >= settle_reg)
                begin
                    lseg_t        = item.min_segment;
                    lcell_t       = item.min_index;
                    lvolt_t       = item.min_voltage;
                    elapsed_t_val = '0;
                    mode_t_val    = MODE_BALANCE;
                    kind          = TICK_WALK;
                end
                else
                begin
                    elapsed_t_val = elapsed_inc;
                end
            end
            MODE_BALANCE:
            begin
                if (!item.enable)
                begin
                    lseg_t     = '0;
                    lcell_t    = '0;
                    lvolt_t    = '0;
                    mode_t_val = MODE_DISABLED;
                    kind       = TICK_MASKS;
                end
                else if (elapsed_inc >= balance_reg)
                begin
                    elapsed_t_val = '0;
                    mode_t_val    = MODE_SETTLE;
                    kind          = TICK_MASKS;
                end
                else
                begin
                    elapsed_t_val = elapsed_inc;
                end
            end
            default:
            begin
                if (item.enable)
                begin
                    elapsed_t_val = '0;
                    mode_t_val    = MODE_SETTLE;
                end
            end
        endcase
    end

    // store write and walk evaluation
    assign rep_in_range = (int'(item.cell_segment) < SEGMENTS)
                       && (int'(item.cell_index) < CELLS);
    assign rep_addr     = ADDR_W'(int'(item.cell_segment) * CELLS + int'(item.cell_index));
    assign mem_we       = cmd.clear_step || (cmd.report_wr && rep_in_range);
    assign mem_waddr    = cmd.clear_step ? addr_cnt_reg : rep_addr;
    assign mem_wdata    = cmd.clear_step ? '0 : {item.cell_valid, item.cell_voltage};

    assign leader_match = (int'(seg_d_reg) == int'(leader_seg_reg))
                       && (int'(cell_d_reg) == int'(leader_cell_reg));
    assign hit = eval_reg && rd_reg[VOLT_W] && !leader_match
              && ({1'b0, rd_reg[VOLT_W-1:0]} >= ({1'b0, leader_volt_reg} + {1'b0, thr_reg}));

    assign cnt_step = cmd.clear_step || cmd.walk_step;

    always_comb
    begin
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        leader_seg_next  = leader_seg_reg;
        leader_cell_next = leader_cell_reg;
        leader_volt_next = leader_volt_reg;
        addr_cnt_next    = addr_cnt_reg;
        seg_cnt_next     = seg_cnt_reg;
        cell_cnt_next    = cell_cnt_reg;
        emit_cnt_next    = emit_cnt_reg;
        for (int s = 0; s < SEGMENTS; s++)
        begin
            mask_next[s] = mask_reg[s];
        end

        if (cmd.tick_load)
        begin
            mode_next        = mode_t_val;
            elapsed_next     = elapsed_t_val;
            leader_seg_next  = lseg_t;
            leader_cell_next = lcell_t;
            leader_volt_next = lvolt_t;
            addr_cnt_next    = '0;
            seg_cnt_next     = '0;
            cell_cnt_next    = '0;
            emit_cnt_next    = '0;
            if (kind != TICK_PLAIN)
            begin
                for (int s = 0; s < SEGMENTS; s++)
                begin
                    mask_next[s] = '0;
                end
            end
        end
        else
        begin
            if (cnt_step)
            begin
                addr_cnt_next = addr_cnt_reg + 1'b1;
                if (cell_cnt_reg == CELL_W'(CELLS - 1))
                begin
                    cell_cnt_next = '0;
                    seg_cnt_next  = seg_cnt_reg + 1'b1;
                end
                else
                begin
                    cell_cnt_next = cell_cnt_reg + 1'b1;
                end
            end
            if (cmd.emit_step)
            begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
            end
            if (hit)
            begin
                for (int s = 0; s < SEGMENTS; s++)
                begin
                    for (int i = 0; i < MASK_W; i++)
                    begin
                        if ((int'(seg_d_reg) == s) && (int'(cell_d_reg) == i))
                        begin
                            mask_next[s][i] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign status.tick_kind = kind;
    assign status.addr_last = (addr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.emit_last = emit_masks_reg ? (emit_cnt_reg == SEG_W'(SEGMENTS - 1)) : 1'b1;

    always_comb
    begin
        result_next                = result_reg;
        result_next.mode           = mode_reg;
        result_next.leader_segment = leader_seg_reg;
        result_next.leader_index   = leader_cell_reg;
        result_next.imbalance      = imb_reg;
        result_next.mask_segment   = emit_masks_reg ? LOC_W'(emit_cnt_reg) : '0;
        result_next.discharge_mask = emit_masks_reg ? mask_reg[emit_cnt_reg] : '0;
        result_next.mask_present   = emit_masks_reg;
        result_next.last           = status.emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THRESHOLD_RST;
            settle_reg      <= SETTLE_RST;
            balance_reg     <= BALANCE_RST;
            mode_reg        <= MODE_DISABLED;
            elapsed_reg     <= '0;
            leader_seg_reg  <= '0;
            leader_cell_reg <= '0;
            leader_volt_reg <= '0;
            for (int s = 0; s < SEGMENTS; s++)
            begin
                mask_reg[s] <= '0;
            end
            emit_masks_reg  <= 1'b0;
            addr_cnt_reg    <= '0;
            seg_cnt_reg     <= '0;
            cell_cnt_reg    <= '0;
            emit_cnt_reg    <= '0;
            eval_reg        <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg     <= cfg_data[VOLT_W-1:0];
                    CFG_SETTLE:    settle_reg  <= cfg_data[TICK_W-1:0];
                    CFG_BALANCE:   balance_reg <= cfg_data[TICK_W-1:0];
                    default:       ;
                endcase
            end
            mode_reg        <= mode_next;
            elapsed_reg     <= elapsed_next;
            leader_seg_reg  <= leader_seg_next;
            leader_cell_reg <= leader_cell_next;
            leader_volt_reg <= leader_volt_next;
            for (int s = 0; s < SEGMENTS; s++)
            begin
                mask_reg[s] <= mask_next[s];
            end
            if (cmd.tick_load)
            begin
                emit_masks_reg <= (kind != TICK_PLAIN);
            end
            addr_cnt_reg    <= addr_cnt_next;
            seg_cnt_reg     <= seg_cnt_next;
            cell_cnt_reg    <= cell_cnt_next;
            emit_cnt_reg    <= emit_cnt_next;
            eval_reg        <= cmd.walk_step;
            strobe_reg      <= cmd.emit_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_load)
        begin
            imb_reg <= (item.max_voltage > item.min_voltage)
                     ? item.max_voltage - item.min_voltage : '0;
        end
        if (cmd.walk_step)
        begin
            seg_d_reg  <= seg_cnt_reg;
            cell_d_reg <= cell_cnt_reg;
        end
        if (cmd.emit_step)
        begin
            result_reg <= result_next;
        end
    end

    // cell store: valid flag above the voltage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.walk_step)
        begin
            rd_reg <= cell_mem[addr_cnt_reg];
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

// ----- rtl/cell_balancing_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_balancing_controller
// Passive balancing controller: cell store, mode timers and discharge masks.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: an item is taken at a clock edge with start high and busy
//   low. A cell report (cmd 0) is written into the cell store in that cycle
//   and gives no result; busy stays low, so reports may come every cycle.
//   A tick (cmd 1) gives one result, or SEGMENTS results when masks change.
//   Results appear on result for one cycle each with strobe high; the
//   receiver cannot stall, and the results of one tick come back to back.
//   Plain tick: busy only in ST_EMIT, where its one result is registered.
//   Mask clear tick (balance expiry, disable): one emit step per segment.
//   Leader tick: the walk reads one store entry per cycle from a single
//   port across all entries, then ST_TAIL and one emit step per segment.
//   cfg channel: always ready; index 0 threshold, 1 settle ticks,
//   2 balance ticks, other indexes ignored. Write only while idle.
//   Reset: after rst_n is released all SEGMENTS*CELLS store entries are
//   swept to invalid, with busy high; config writes still taken.
// ----------------------------------------------------------------------------
module cell_balancing_controller
    import cbc_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF,
    parameter int CELLS    = CELLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  strobe,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item_cmd (item.cmd),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    cbc_datapath #(
        .SEGMENTS (SEGMENTS),
        .CELLS    (CELLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .strobe    (strobe)
    );

`ifndef SYNTH
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("result burst broken");

    a_report_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.cmd == CMD_REPORT) |=> !strobe)
        else $error("result after cell report");

    a_plain_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.mask_present |-> result.last)
        else $error("plain result not last");

    a_mask_last_seg: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.mask_present && result.last
            |-> result.mask_segment == LOC_W'(SEGMENTS - 1))
        else $error("mask burst ends early");
`endif

endmodule
